// ===== src/ymr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ymr_pkg
// Types, codes and helpers shared by the YMODEM receive block.
// ---------------------------------------------------------------------------
package ymr_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;

    // control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [10:0] SMALL_SIZE = 11'd128;
    localparam logic [10:0] BIG_SIZE   = 11'd1024;

    // reply codes
    localparam logic [2:0] REP_NONE = 3'd0;
    localparam logic [2:0] REP_ACK  = 3'd1;
    localparam logic [2:0] REP_NAK  = 3'd2;
    localparam logic [2:0] REP_C    = 3'd3;
    localparam logic [2:0] REP_CAN  = 3'd4;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_COMMIT  = 3'd1;
    localparam logic [2:0] EV_HEADER  = 3'd2;
    localparam logic [2:0] EV_FILEEND = 3'd3;
    localparam logic [2:0] EV_SUCCESS = 3'd4;
    localparam logic [2:0] EV_EMPTY   = 3'd5;
    localparam logic [2:0] EV_ERROR   = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT    = 3'd1;
    localparam logic [2:0] ERR_ABORTED    = 3'd2;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
    localparam logic [2:0] ERR_NAME_LONG  = 3'd4;
    localparam logic [2:0] ERR_PROTOCOL   = 3'd5;
    localparam logic [2:0] ERR_OVERRUN    = 3'd6;

    // timer selects
    localparam logic [2:0] TMO_CHAR    = 3'd0;
    localparam logic [2:0] TMO_FIVE    = 3'd1;
    localparam logic [2:0] TMO_HALF    = 3'd2;
    localparam logic [2:0] TMO_MINUTE  = 3'd3;
    localparam logic [2:0] TMO_TEN     = 3'd4;
    localparam logic [2:0] TMO_INITIAL = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_USE_CRC  = 2'd0;
    localparam logic [1:0] CFG_MAX_TMO  = 2'd1;
    localparam logic [1:0] CFG_MAX_NAME = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  reply;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  data_offset;
        logic [2:0]  event_res;
        logic [2:0]  error_code;
        logic [10:0] commit_length;
        logic [31:0] declared_length;
        logic [2:0]  timeout_select;
        logic        length_overflow;
    } result_t;

    // crc-16/xmodem, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== src/ymodem_receiver.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ymodem_receiver
// Receive side of a YMODEM batch: packet framing, check, header parse, commit.
// ---------------------------------------------------------------------------
// Usage: each transfer on the item channel is one received byte (mode 0) or
// the expiry of the timer last selected (mode 1). Every item gives exactly one
// result on the result channel: the reply to send, a tentative payload byte,
// an event with error code and commit length, the declared length and the
// timer to arm next.
// The result is registered and valid in the cycle after the item transfer. One
// item is taken per cycle while the result channel does not stall; the whole
// per-byte update sits between the state registers and the result register.
// When the result channel stalls, the held result stays and the item channel
// stalls until the result is taken; a new item may be taken in the same cycle
// the held result leaves.
// Configuration writes (use_crc, max_start_timeouts, max_name_length) take
// effect at the clock edge where the write enable is high.
// Reset puts the block in wait-for-first-packet with the initial timer armed
// and the result register empty.
// ---------------------------------------------------------------------------
module ymodem_receiver #(
    parameter int LENGTH_BITS = ymr_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ymr_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ymr_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    localparam logic [2:0] PH_WAIT_FIRST = 3'd0;
    localparam logic [2:0] PH_IN_PACKET  = 3'd1;
    localparam logic [2:0] PH_WAIT_NEXT  = 3'd2;
    localparam logic [2:0] PH_DRAIN      = 3'd3;
    localparam logic [2:0] PH_ENDED      = 3'd4;

    localparam logic [1:0] HP_NAME   = 2'd0;
    localparam logic [1:0] HP_DIGITS = 2'd1;
    localparam logic [1:0] HP_DONE   = 2'd2;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic use_crc_reg;
    logic [3:0] max_tmo_reg;
    logic [7:0] max_name_reg;

    logic [2:0] phase_reg, phase_next;
    logic [10:0] idx_reg, idx_next;
    logic big_reg, big_next;
    logic [7:0] seq_reg, seq_next;
    logic [15:0] check_reg, check_next;
    logic [7:0] chk_hi_reg, chk_hi_next;
    logic first_reg, first_next;
    logic [7:0] last_seq_reg, last_seq_next;
    logic [LENGTH_BITS-1:0] file_len_reg, file_len_next;
    logic [LENGTH_BITS-1:0] rcv_reg, rcv_next;
    logic [3:0] start_tmo_reg, start_tmo_next;
    logic [1:0] hp_reg, hp_next;
    logic [7:0] name_cnt_reg, name_cnt_next;
    logic [LENGTH_BITS-1:0] accum_reg, accum_next;
    logic accum_ovf_reg, accum_ovf_next;
    logic name_empty_reg, name_empty_next;
    logic name_long_reg, name_long_next;
    logic len_flag_reg, len_flag_next;
    logic [2:0] armed_reg, armed_next;

    logic result_valid_reg;
    ymr_pkg::result_t result_reg, res;

    logic take;
    logic [7:0] b;
    logic [10:0] size, total, off;
    logic [3:0] start_inc;
    logic [LENGTH_BITS+3:0] prod;
    logic [LENGTH_BITS-1:0] slice_full;
    logic [10:0] slice;
    logic ok;
    logic [LENGTH_BITS+31:0] decl_ext;

    assign item_stall   = result_valid_reg && result_stall;
    assign take         = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign b     = item.rx_byte;
    assign size  = big_reg ? ymr_pkg::BIG_SIZE : ymr_pkg::SMALL_SIZE;
    assign total = size + (use_crc_reg ? 11'd5 : 11'd4);
    assign off   = idx_reg - 11'd3;
    assign start_inc = (start_tmo_reg < 4'd15) ? start_tmo_reg + 4'd1 : start_tmo_reg;
    // accum * 10 + digit, upper bits flag saturation
    assign prod = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                + {{LENGTH_BITS{1'b0}}, 4'(b - ymr_pkg::CH_ZERO)};
    assign slice_full = file_len_reg - rcv_reg;
    assign slice = (slice_full > {{(LENGTH_BITS-11){1'b0}}, size}) ? size : slice_full[10:0];
    assign ok = use_crc_reg ? (check_reg[15:8] == chk_hi_reg && check_reg[7:0] == b)
                            : (check_reg[7:0] == b);

    always_comb
    begin
        phase_next = phase_reg; idx_next = idx_reg; big_next = big_reg;
        seq_next = seq_reg; check_next = check_reg; chk_hi_next = chk_hi_reg;
        first_next = first_reg; last_seq_next = last_seq_reg;
        file_len_next = file_len_reg; rcv_next = rcv_reg;
        start_tmo_next = start_tmo_reg; hp_next = hp_reg;
        name_cnt_next = name_cnt_reg; accum_next = accum_reg;
        accum_ovf_next = accum_ovf_reg; name_empty_next = name_empty_reg;
        name_long_next = name_long_reg; len_flag_next = len_flag_reg;
        armed_next = armed_reg;
        res = '0;

        case (phase_reg)
            PH_WAIT_FIRST, PH_WAIT_NEXT:
            begin
                if (item.mode)
                begin
                    if (phase_reg == PH_WAIT_NEXT)
                    begin
                        res.reply = ymr_pkg::REP_CAN; res.event_res = ymr_pkg::EV_ERROR;
                        res.error_code = ymr_pkg::ERR_TIMEOUT; phase_next = PH_ENDED;
                    end
                    else
                    begin
                        start_tmo_next = start_inc;
                        if (start_inc >= max_tmo_reg)
                        begin
                            res.reply = ymr_pkg::REP_CAN; res.event_res = ymr_pkg::EV_ERROR;
                            res.error_code = ymr_pkg::ERR_TIMEOUT; phase_next = PH_ENDED;
                        end
                        else
                        begin
                            res.reply = use_crc_reg ? ymr_pkg::REP_C : ymr_pkg::REP_NAK;
                            armed_next = ymr_pkg::TMO_FIVE;
                        end
                    end
                end
                else if (b == ymr_pkg::CH_SOH || b == ymr_pkg::CH_STX)
                begin
                    big_next = (b == ymr_pkg::CH_STX);
                    idx_next = 11'd1;
                    check_next = '0; chk_hi_next = '0;
                    hp_next = HP_NAME; name_cnt_next = '0; accum_next = '0;
                    accum_ovf_next = 1'b0; name_empty_next = 1'b0; name_long_next = 1'b0;
                    armed_next = ymr_pkg::TMO_CHAR;
                    phase_next = PH_IN_PACKET;
                end
                else if (b == ymr_pkg::CH_CAN || b == ymr_pkg::CH_NAK)
                begin
                    res.reply = ymr_pkg::REP_CAN; res.event_res = ymr_pkg::EV_ERROR;
                    res.error_code = ymr_pkg::ERR_ABORTED; phase_next = PH_ENDED;
                end
                else if (b == ymr_pkg::CH_EOT)
                begin
                    if (rcv_reg >= file_len_reg)
                    begin
                        res.reply = ymr_pkg::REP_ACK; res.event_res = ymr_pkg::EV_FILEEND;
                        first_next = 1'b1; phase_next = PH_WAIT_FIRST; start_tmo_next = '0;
                    end
                    else
                    begin
                        res.reply = ymr_pkg::REP_CAN; res.event_res = ymr_pkg::EV_ERROR;
                        res.error_code = ymr_pkg::ERR_INCOMPLETE; phase_next = PH_ENDED;
                    end
                end
            end
            PH_IN_PACKET:
            begin
                if (item.mode)
                begin
                    res.reply = ymr_pkg::REP_NAK;
                    idx_next = '0;
                    if (rcv_reg == '0)
                    begin
                        armed_next = ymr_pkg::TMO_FIVE; phase_next = PH_WAIT_FIRST;
                        start_tmo_next = '0;
                    end
                    else
                    begin
                        armed_next = ymr_pkg::TMO_MINUTE; phase_next = PH_WAIT_NEXT;
                    end
                end
                else if (idx_reg == 11'd2 && seq_reg != ~b)
                begin
                    // complement mismatch: drop the rest until the line is quiet
                    phase_next = PH_DRAIN; armed_next = ymr_pkg::TMO_CHAR; idx_next = '0;
                end
                else
                begin
                    if (idx_reg == 11'd1)
                        seq_next = b;
                    else if (idx_reg >= 11'd3 && idx_reg < size + 11'd3)
                    begin
                        check_next = use_crc_reg ? ymr_pkg::crc_byte(check_reg, b)
                                                 : {8'd0, check_reg[7:0] + b};
                        if (first_reg)
                        begin
                            if (seq_reg == 8'd0)
                            begin
                                case (hp_reg)
                                    HP_NAME:
                                    begin
                                        if (b == 8'd0)
                                        begin
                                            if (off == '0) name_empty_next = 1'b1;
                                            hp_next = HP_DIGITS;
                                        end
                                        else if (name_cnt_reg >= max_name_reg)
                                            name_long_next = 1'b1;
                                        else
                                            name_cnt_next = name_cnt_reg + 8'd1;
                                    end
                                    HP_DIGITS:
                                    begin
                                        if (b >= ymr_pkg::CH_ZERO && b <= ymr_pkg::CH_NINE)
                                        begin
                                            if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                            begin
                                                accum_next = LEN_MAX; accum_ovf_next = 1'b1;
                                            end
                                            else
                                                accum_next = prod[LENGTH_BITS-1:0];
                                        end
                                        else
                                            hp_next = HP_DONE;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        else
                        begin
                            res.data_valid = 1'b1; res.data_byte = b;
                            res.data_offset = off[9:0];
                        end
                    end
                    else if (idx_reg == size + 11'd3 && use_crc_reg)
                        chk_hi_next = b;

                    if (idx_reg + 11'd1 >= total)
                    begin
                        phase_next = PH_WAIT_NEXT; idx_next = '0;
                        if (!ok)
                            res.reply = ymr_pkg::REP_NAK;
                        else if (first_reg || (last_seq_reg + 8'd1) == seq_reg)
                        begin
                            if (file_len_reg != '0 && rcv_reg >= file_len_reg)
                            begin
                                res.reply = ymr_pkg::REP_ACK; res.event_res = ymr_pkg::EV_SUCCESS;
                                phase_next = PH_ENDED;
                            end
                            else
                            begin
                                last_seq_next = seq_reg;
                                first_next = 1'b0;
                                if (first_reg && seq_reg == 8'd0)
                                begin
                                    if (name_empty_reg)
                                    begin
                                        res.reply = ymr_pkg::REP_ACK;
                                        res.event_res = ymr_pkg::EV_EMPTY; phase_next = PH_ENDED;
                                    end
                                    else if (name_long_reg)
                                    begin
                                        res.reply = ymr_pkg::REP_CAN; res.event_res = ymr_pkg::EV_ERROR;
                                        res.error_code = ymr_pkg::ERR_NAME_LONG;
                                        phase_next = PH_ENDED;
                                    end
                                    else
                                    begin
                                        res.reply = ymr_pkg::REP_ACK;
                                        res.event_res = ymr_pkg::EV_HEADER;
                                        file_len_next = accum_reg; len_flag_next = accum_ovf_reg;
                                        rcv_next = '0; armed_next = ymr_pkg::TMO_HALF;
                                        phase_next = PH_WAIT_FIRST; start_tmo_next = '0;
                                    end
                                end
                                else if (first_reg)
                                begin
                                    res.reply = ymr_pkg::REP_CAN; res.event_res = ymr_pkg::EV_ERROR;
                                    res.error_code = ymr_pkg::ERR_PROTOCOL; phase_next = PH_ENDED;
                                end
                                else if (rcv_reg >= file_len_reg)
                                begin
                                    res.reply = ymr_pkg::REP_CAN; res.event_res = ymr_pkg::EV_ERROR;
                                    res.error_code = ymr_pkg::ERR_OVERRUN; phase_next = PH_ENDED;
                                end
                                else
                                begin
                                    rcv_next = rcv_reg + {{(LENGTH_BITS-11){1'b0}}, slice};
                                    res.reply = ymr_pkg::REP_ACK;
                                    res.event_res = ymr_pkg::EV_COMMIT;
                                    res.commit_length = slice;
                                end
                            end
                        end
                        else if (last_seq_reg == seq_reg)
                            res.reply = ymr_pkg::REP_ACK;
                        else
                            res.reply = ymr_pkg::REP_NAK;
                    end
                    else
                        idx_next = idx_reg + 11'd1;
                end
            end
            PH_DRAIN:
            begin
                if (item.mode)
                begin
                    res.reply = ymr_pkg::REP_NAK;
                    if (rcv_reg == '0)
                    begin
                        armed_next = ymr_pkg::TMO_TEN; phase_next = PH_WAIT_FIRST;
                        start_tmo_next = '0;
                    end
                    else
                        phase_next = PH_WAIT_NEXT;
                end
            end
            default: ;
        endcase

        decl_ext = {32'd0, file_len_next};
        res.declared_length = decl_ext[31:0];
        res.timeout_select  = armed_next;
        res.length_overflow = len_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_crc_reg <= 1'b1; max_tmo_reg <= 4'd7; max_name_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ymr_pkg::CFG_USE_CRC:  use_crc_reg <= cfg_data[0];
                ymr_pkg::CFG_MAX_TMO:  max_tmo_reg <= cfg_data[3:0];
                ymr_pkg::CFG_MAX_NAME: max_name_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_FIRST; idx_reg <= '0; big_reg <= 1'b0; seq_reg <= '0;
            check_reg <= '0; chk_hi_reg <= '0; first_reg <= 1'b1; last_seq_reg <= '0;
            file_len_reg <= '0; rcv_reg <= '0; start_tmo_reg <= '0; hp_reg <= HP_NAME;
            name_cnt_reg <= '0; accum_reg <= '0; accum_ovf_reg <= 1'b0;
            name_empty_reg <= 1'b0; name_long_reg <= 1'b0; len_flag_reg <= 1'b0;
            armed_reg <= ymr_pkg::TMO_INITIAL;
        end
        else if (take)
        begin
            phase_reg <= phase_next; idx_reg <= idx_next; big_reg <= big_next;
            seq_reg <= seq_next; check_reg <= check_next; chk_hi_reg <= chk_hi_next;
            first_reg <= first_next; last_seq_reg <= last_seq_next;
            file_len_reg <= file_len_next; rcv_reg <= rcv_next;
            start_tmo_reg <= start_tmo_next; hp_reg <= hp_next;
            name_cnt_reg <= name_cnt_next; accum_reg <= accum_next;
            accum_ovf_reg <= accum_ovf_next; name_empty_reg <= name_empty_next;
            name_long_reg <= name_long_next; len_flag_reg <= len_flag_next;
            armed_reg <= armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (take)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= res;
    end

    // payload and an event never share one result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.data_valid && result_reg.event_res != ymr_pkg::EV_NONE))
        else $error("payload byte and event in one result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            ((result_reg.error_code != ymr_pkg::ERR_NONE) ==
             (result_reg.event_res == ymr_pkg::EV_ERROR)))
        else $error("error code does not match event");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.event_res != ymr_pkg::EV_COMMIT) |->
            result_reg.commit_length == 11'd0)
        else $error("commit length outside commit event");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(result_reg)))
        else $error("held result lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ENDED) |=> (phase_reg == PH_ENDED))
        else $error("left ended phase");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the YMODEM receive block: a model of the block
// predicts one result per byte or timeout transfer, a monitor compares them.
// ---------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 1500000;

    typedef enum logic [2:0] {
        PH_WAIT_FIRST,
        PH_IN_PACKET,
        PH_WAIT_NEXT,
        PH_DRAIN,
        PH_ENDED
    } phase_t;

    typedef enum logic [1:0] {
        HDR_NAME,
        HDR_DIGITS,
        HDR_DONE
    } hdr_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    ymr_pkg::item_t item;
    logic result_valid;
    logic result_stall;
    ymr_pkg::result_t result;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    ymodem_receiver dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // model configuration and state
    logic m_use_crc;
    logic [3:0] m_max_tmo;
    logic [7:0] m_max_name;
    phase_t m_phase;
    hdr_t m_hdr;
    logic [10:0] m_idx;
    logic m_big;
    logic [7:0] m_seq;
    logic [7:0] m_last_seq;
    logic [15:0] m_check;
    logic [7:0] m_check_hi;
    logic m_first;
    logic [31:0] m_file_len;
    logic [31:0] m_rcvd;
    logic [3:0] m_tmo_count;
    logic [7:0] m_name_count;
    logic [31:0] m_accum;
    logic m_accum_ovf;
    logic m_name_empty;
    logic m_name_long;
    logic m_len_flag;
    logic [2:0] m_armed;

    ymr_pkg::item_t pending_items[$];
    ymr_pkg::result_t expected_results[$];
    int errors;
    int cycles;
    int result_hold;
    bit stimulus_done;

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    task automatic model_reset();
        m_use_crc = 1'b1;
        m_max_tmo = 4'd7;
        m_max_name = 8'd255;
        m_phase = PH_WAIT_FIRST;
        m_hdr = HDR_NAME;
        m_idx = '0;
        m_big = 1'b0;
        m_seq = '0;
        m_last_seq = '0;
        m_check = '0;
        m_check_hi = '0;
        m_first = 1'b1;
        m_file_len = '0;
        m_rcvd = '0;
        m_tmo_count = '0;
        m_name_count = '0;
        m_accum = '0;
        m_accum_ovf = 1'b0;
        m_name_empty = 1'b0;
        m_name_long = 1'b0;
        m_len_flag = 1'b0;
        m_armed = ymr_pkg::TMO_INITIAL;
    endtask

    function automatic void fail_with(inout ymr_pkg::result_t r, input logic [2:0] code);
        r.reply = ymr_pkg::REP_CAN;
        r.event_res = ymr_pkg::EV_ERROR;
        r.error_code = code;
        m_phase = PH_ENDED;
    endfunction

    function automatic void parse_header(input logic [7:0] b, input logic [9:0] off);
        logic [31:0] d;
        if (m_hdr == HDR_NAME)
        begin
            if (b == 8'h00)
            begin
                if (off == 0)
                    m_name_empty = 1'b1;
                m_hdr = HDR_DIGITS;
            end
            else if (m_name_count >= m_max_name)
                m_name_long = 1'b1;
            else
                m_name_count++;
        end
        else if (m_hdr == HDR_DIGITS)
        begin
            if (b >= ymr_pkg::CH_ZERO && b <= ymr_pkg::CH_NINE)
            begin
                d = 32'(b - ymr_pkg::CH_ZERO);
                if (m_accum > (32'hffff_ffff - d) / 10)
                begin
                    m_accum = 32'hffff_ffff;
                    m_accum_ovf = 1'b1;
                end
                else
                    m_accum = m_accum * 10 + d;
            end
            else
                m_hdr = HDR_DONE;
        end
    endfunction

    function automatic void finish_packet(inout ymr_pkg::result_t r, input logic [7:0] b,
                                          input logic [10:0] size);
        logic ok;
        logic [31:0] slice;
        m_phase = PH_WAIT_NEXT;
        m_idx = '0;
        if (m_use_crc)
            ok = (m_check[15:8] == m_check_hi) && (m_check[7:0] == b);
        else
            ok = (m_check[7:0] == b);
        if (!ok)
        begin
            r.reply = ymr_pkg::REP_NAK;
            return;
        end
        if (m_first || (8'(m_last_seq + 1) == m_seq))
        begin
            if (m_file_len > 0 && m_rcvd >= m_file_len)
            begin
                r.reply = ymr_pkg::REP_ACK;
                r.event_res = ymr_pkg::EV_SUCCESS;
                m_phase = PH_ENDED;
                return;
            end
            m_last_seq = m_seq;
            if (m_first && m_seq == 0)
            begin
                if (m_name_empty)
                begin
                    r.reply = ymr_pkg::REP_ACK;
                    r.event_res = ymr_pkg::EV_EMPTY;
                    m_phase = PH_ENDED;
                    return;
                end
                if (m_name_long)
                begin
                    fail_with(r, ymr_pkg::ERR_NAME_LONG);
                    return;
                end
                r.reply = ymr_pkg::REP_ACK;
                r.event_res = ymr_pkg::EV_HEADER;
                m_file_len = m_accum;
                m_len_flag = m_accum_ovf;
                m_rcvd = '0;
                m_armed = ymr_pkg::TMO_HALF;
                m_phase = PH_WAIT_FIRST;
                m_tmo_count = '0;
            end
            else
            begin
                if (m_first)
                begin
                    fail_with(r, ymr_pkg::ERR_PROTOCOL);
                    return;
                end
                if (m_rcvd >= m_file_len)
                begin
                    fail_with(r, ymr_pkg::ERR_OVERRUN);
                    return;
                end
                slice = m_file_len - m_rcvd;
                if (slice > 32'(size))
                    slice = 32'(size);
                m_rcvd += slice;
                r.reply = ymr_pkg::REP_ACK;
                r.event_res = ymr_pkg::EV_COMMIT;
                r.commit_length = slice[10:0];
            end
            m_first = 1'b0;
        end
        else if (m_last_seq == m_seq)
            r.reply = ymr_pkg::REP_ACK;
        else
            r.reply = ymr_pkg::REP_NAK;
    endfunction

    function automatic ymr_pkg::result_t predict_reply(input ymr_pkg::item_t it);
        ymr_pkg::result_t r;
        logic [7:0] b;
        logic [10:0] size;
        logic [10:0] total;
        logic [10:0] idx;
        r = '0;
        b = it.rx_byte;
        if (m_phase == PH_WAIT_FIRST || m_phase == PH_WAIT_NEXT)
        begin
            if (it.mode)
            begin
                if (m_phase == PH_WAIT_NEXT)
                    fail_with(r, ymr_pkg::ERR_TIMEOUT);
                else
                begin
                    if (m_tmo_count < 15)
                        m_tmo_count++;
                    if (m_tmo_count >= m_max_tmo)
                        fail_with(r, ymr_pkg::ERR_TIMEOUT);
                    else
                    begin
                        r.reply = m_use_crc ? ymr_pkg::REP_C : ymr_pkg::REP_NAK;
                        m_armed = ymr_pkg::TMO_FIVE;
                    end
                end
            end
            else if (b == ymr_pkg::CH_SOH || b == ymr_pkg::CH_STX)
            begin
                m_big = (b == ymr_pkg::CH_STX);
                m_idx = 11'd1;
                m_check = '0;
                m_check_hi = '0;
                m_hdr = HDR_NAME;
                m_name_count = '0;
                m_accum = '0;
                m_accum_ovf = 1'b0;
                m_name_empty = 1'b0;
                m_name_long = 1'b0;
                m_armed = ymr_pkg::TMO_CHAR;
                m_phase = PH_IN_PACKET;
            end
            else if (b == ymr_pkg::CH_CAN || b == ymr_pkg::CH_NAK)
                fail_with(r, ymr_pkg::ERR_ABORTED);
            else if (b == ymr_pkg::CH_EOT)
            begin
                if (m_rcvd >= m_file_len)
                begin
                    r.reply = ymr_pkg::REP_ACK;
                    r.event_res = ymr_pkg::EV_FILEEND;
                    m_first = 1'b1;
                    m_phase = PH_WAIT_FIRST;
                    m_tmo_count = '0;
                end
                else
                    fail_with(r, ymr_pkg::ERR_INCOMPLETE);
            end
        end
        else if (m_phase == PH_IN_PACKET)
        begin
            if (it.mode)
            begin
                r.reply = ymr_pkg::REP_NAK;
                m_idx = '0;
                if (m_rcvd == 0)
                begin
                    m_armed = ymr_pkg::TMO_FIVE;
                    m_phase = PH_WAIT_FIRST;
                    m_tmo_count = '0;
                end
                else
                begin
                    m_armed = ymr_pkg::TMO_MINUTE;
                    m_phase = PH_WAIT_NEXT;
                end
            end
            else
            begin
                size = m_big ? ymr_pkg::BIG_SIZE : ymr_pkg::SMALL_SIZE;
                total = size + 11'd3 + (m_use_crc ? 11'd2 : 11'd1);
                idx = m_idx;
                if (idx == 1)
                    m_seq = b;
                else if (idx == 2 && m_seq != ~b)
                begin
                    m_phase = PH_DRAIN;
                    m_armed = ymr_pkg::TMO_CHAR;
                    m_idx = '0;
                end
                else if (idx >= 3 && idx < size + 3)
                begin
                    m_check = m_use_crc ? crc_next(m_check, b) : {8'h00, 8'(m_check[7:0] + b)};
                    if (m_first)
                    begin
                        if (m_seq == 0)
                            parse_header(b, 10'(idx - 3));
                    end
                    else
                    begin
                        r.data_valid = 1'b1;
                        r.data_byte = b;
                        r.data_offset = 10'(idx - 3);
                    end
                end
                else if (idx == size + 3 && m_use_crc)
                    m_check_hi = b;
                if (m_phase == PH_IN_PACKET)
                begin
                    if (idx + 1 >= total)
                        finish_packet(r, b, size);
                    else
                        m_idx = idx + 1;
                end
            end
        end
        else if (m_phase == PH_DRAIN)
        begin
            if (it.mode)
            begin
                r.reply = ymr_pkg::REP_NAK;
                if (m_rcvd == 0)
                begin
                    m_armed = ymr_pkg::TMO_TEN;
                    m_phase = PH_WAIT_FIRST;
                    m_tmo_count = '0;
                end
                else
                    m_phase = PH_WAIT_NEXT;
            end
        end
        r.declared_length = m_file_len;
        r.timeout_select = m_armed;
        r.length_overflow = m_len_flag;
        return r;
    endfunction

    // ---- stimulus builders, all through the model's view of the packet check ----
    task automatic push_byte(input logic [7:0] b);
        ymr_pkg::item_t it;
        it.mode = 1'b0;
        it.rx_byte = b;
        pending_items.push_back(it);
    endtask

    task automatic push_timeout();
        ymr_pkg::item_t it;
        it.mode = 1'b1;
        it.rx_byte = 8'($urandom);
        pending_items.push_back(it);
    endtask

    // payload bytes, optional corrupt trailer or bad complement (then no payload); crc flag is the setting in force
    task automatic push_packet(input logic big, input logic [7:0] seq, input logic [7:0] body[],
                               input logic crc, input logic corrupt, input logic bad_cpl);
        logic [15:0] chk;
        int n;
        n = big ? 1024 : 128;
        chk = '0;
        push_byte(big ? ymr_pkg::CH_STX : ymr_pkg::CH_SOH);
        push_byte(seq);
        push_byte(bad_cpl ? seq : ~seq);
        if (bad_cpl)
            return;
        for (int i = 0; i < n; i++)
        begin
            push_byte(body[i]);
            chk = crc ? crc_next(chk, body[i]) : {8'h00, 8'(chk[7:0] + body[i])};
        end
        if (corrupt)
            chk ^= 16'h0001 << $urandom_range(0, 15);
        if (crc)
            push_byte(chk[15:8]);
        push_byte(chk[7:0]);
    endtask

    task automatic push_header(input logic big, input string name, input string len,
                               input logic crc, input logic pad_digits);
        logic [7:0] body[];
        int n;
        int p;
        n = big ? 1024 : 128;
        body = new[n];
        foreach (body[i])
            body[i] = 8'h00;
        p = 0;
        for (int i = 0; i < name.len() && p < n; i++)
            body[p++] = name[i];
        p++;
        for (int i = 0; i < len.len() && p < n; i++)
            body[p++] = len[i];
        if (pad_digits && p < n)
            body[p] = 8'h20;
        push_packet(big, 8'h00, body, crc, 1'b0, 1'b0);
    endtask

    task automatic push_data(input logic big, input logic [7:0] seq, input logic crc,
                             input logic corrupt, input logic bad_cpl);
        logic [7:0] body[];
        body = new[big ? 1024 : 128];
        foreach (body[i])
            body[i] = 8'($urandom);
        push_packet(big, seq, body, crc, corrupt, bad_cpl);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == ymr_pkg::CFG_USE_CRC)
            m_use_crc = value[0];
        else if (index == ymr_pkg::CFG_MAX_TMO)
            m_max_tmo = value[3:0];
        else
            m_max_name = value;
    endtask

    // restart the session: the block ends for good, so a fresh session needs
    // its state back; without a second reset we only keep running sessions
    // that have not ended, and once ended the block is exercised in its ended state

    task automatic random_name(output string s, input int n);
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'($urandom_range(8'h21, 8'h7e)))};
    endtask

    function automatic string dec_string(input longint unsigned v);
        return $sformatf("%0d", v);
    endfunction

    int gen_count;

    // well-formed files, as many as files, with some noise; queues the items and returns
    task automatic push_session(input int files);
        string nm;
        int len;
        int npk;
        logic [7:0] seq;
        logic big;
        for (int f = 0; f < files; f++)
        begin
            random_name(nm, $urandom_range(1, 12));
            len = $urandom_range(1, 100);
            push_header(1'b0, nm, dec_string(len), m_use_crc, $urandom_range(0, 1));
            npk = 0;
            seq = 8'd1;
            while (len > 0)
            begin
                big = 1'b0;
                case ($urandom_range(0, 11))
                    0: push_data(big, seq, m_use_crc, 1'b1, 1'b0);
                    1: push_data(big, seq, m_use_crc, 1'b0, 1'b1);
                    2: push_timeout();
                    3: push_byte(8'($urandom_range(8'h40, 8'hff)));
                    default:
                    begin
                        push_data(big, seq, m_use_crc, 1'b0, 1'b0);
                        if ($urandom_range(0, 5) == 0)
                            push_data(big, seq, m_use_crc, 1'b0, 1'b0);
                        len -= big ? 1024 : 128;
                        seq++;
                    end
                endcase
            end
            push_byte(ymr_pkg::CH_EOT);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 9) > 1)
            begin
                ymr_pkg::item_t it;
                it = pending_items.pop_front();
                expected_results.push_back(predict_reply(it));
                item_valid <= 1'b1;
                item <= it;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            result_hold <= 0;
        end
        else if (result_hold > 0)
        begin
            result_hold <= result_hold - 1;
            result_stall <= (result_hold > 1);
        end
        else if (cycles == 200 || $urandom_range(0, 399) == 0)
        begin
            result_hold <= 60;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            result_hold <= $urandom_range(5, 20);
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 9) == 0);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                ymr_pkg::result_t e;
                e = expected_results.pop_front();
                if (result.reply !== e.reply)
                begin
                    $error("reply exp %0d got %0d", e.reply, result.reply);
                    errors++;
                end
                if (result.data_valid !== e.data_valid)
                begin
                    $error("data_valid exp %0d got %0d", e.data_valid, result.data_valid);
                    errors++;
                end
                if (result.data_byte !== e.data_byte)
                begin
                    $error("data_byte exp %0h got %0h", e.data_byte, result.data_byte);
                    errors++;
                end
                if (result.data_offset !== e.data_offset)
                begin
                    $error("data_offset exp %0d got %0d", e.data_offset, result.data_offset);
                    errors++;
                end
                if (result.event_res !== e.event_res)
                begin
                    $error("event_res exp %0d got %0d", e.event_res, result.event_res);
                    errors++;
                end
                if (result.error_code !== e.error_code)
                begin
                    $error("error_code exp %0d got %0d", e.error_code, result.error_code);
                    errors++;
                end
                if (result.commit_length !== e.commit_length)
                begin
                    $error("commit_length exp %0d got %0d", e.commit_length,
                           result.commit_length);
                    errors++;
                end
                if (result.declared_length !== e.declared_length)
                begin
                    $error("declared_length exp %0d got %0d", e.declared_length,
                           result.declared_length);
                    errors++;
                end
                if (result.timeout_select !== e.timeout_select)
                begin
                    $error("timeout_select exp %0d got %0d", e.timeout_select,
                           result.timeout_select);
                    errors++;
                end
                if (result.length_overflow !== e.length_overflow)
                begin
                    $error("length_overflow exp %0d got %0d", e.length_overflow,
                           result.length_overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        stimulus_done = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: start timeouts with checksum mode, then header limits
        write_reg(ymr_pkg::CFG_USE_CRC, 8'd0);
        write_reg(ymr_pkg::CFG_MAX_TMO, 8'd15);
        write_reg(ymr_pkg::CFG_MAX_NAME, 8'd4);
        push_timeout();
        push_byte(8'hff);
        push_byte(8'h00);
        push_timeout();
        push_data(1'b1, 8'h00, 1'b0, 1'b0, 1'b1); // bad complement, then drain
        push_byte(8'h7e);
        push_timeout();
        push_byte(ymr_pkg::CH_SOH);
        push_timeout();                            // timeout mid-packet
        wait_idle();
        write_reg(ymr_pkg::CFG_USE_CRC, 8'd1);
        write_reg(ymr_pkg::CFG_MAX_NAME, 8'd255);
        write_reg(ymr_pkg::CFG_MAX_TMO, 8'd1);
        // header with a length that saturates
        push_header(1'b0, "f", "99999999999", 1'b1, 1'b1);
        push_data(1'b0, 8'd1, 1'b1, 1'b0, 1'b0);
        push_data(1'b0, 8'd1, 1'b1, 1'b0, 1'b0);   // duplicate
        push_data(1'b0, 8'd5, 1'b1, 1'b0, 1'b0);   // out of order
        push_data(1'b0, 8'd2, 1'b1, 1'b1, 1'b0);   // bad crc
        wait_idle();

        // random: one more file with well-formed packets and some noise
        write_reg(ymr_pkg::CFG_MAX_TMO, 8'd15);
        write_reg(ymr_pkg::CFG_MAX_NAME, 8'd40);
        gen_count = 0;
        push_session(1);
        wait_idle();
        // the session above may still be open: finish with noise and ending events
        for (int i = 0; i < 20; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_timeout();
            else
                push_byte(8'($urandom));
        end
        push_byte(ymr_pkg::CH_CAN);
        wait_idle();

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ymr_pkg.sv
src/ymodem_receiver.sv
tb/sv/testbench.sv
